// ===== rtl/pncs_pkg.sv =====
// Shared types and constants of the palette nearest-color selector.
package pncs_pkg;

  // Palette table geometry and field widths
  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int unsigned SIZE_W        = 9;
  localparam int unsigned COLOR_W       = 24;
  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned DIST_W        = CHAN_W + 2;

  localparam logic [SIZE_W-1:0]  DEPTH_SIZE  = SIZE_W'(PALETTE_DEPTH);
  localparam logic [COLOR_W-1:0] FG_RESET    = 24'hFF_FFFF;
  localparam logic [COLOR_W-1:0] BG_RESET    = 24'h00_0000;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SET   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_PALETTE = 2'd1,
    ST_RANGE      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LOOKUP,
    S_SCAN,
    S_PICK,
    S_RESULT
  } state_e;

  // Control from the sequencer to the nearest-entry tracker
  typedef struct packed {
    logic              start;  // clear tracker before a new search
    logic              vld;    // memory read data belongs to the search
    logic [ADDR_W-1:0] idx;    // entry index of that read data
  } scan_ctl_t;

endpackage

// ===== rtl/pncs_palette_ram.sv =====
// Palette table: one write port, one read port with registered read data.
module pncs_palette_ram (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [pncs_pkg::ADDR_W-1:0]            wr_addr_i,
  input  logic [pncs_pkg::COLOR_W-1:0]           wr_data_i,
  input  logic                                   rd_en_i,
  input  logic [pncs_pkg::ADDR_W-1:0]            rd_addr_i,
  output logic [pncs_pkg::COLOR_W-1:0]           rd_data_o
);

  logic [pncs_pkg::COLOR_W-1:0] mem [pncs_pkg::PALETTE_DEPTH];
  logic [pncs_pkg::COLOR_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/pncs_nearest.sv =====
// Nearest-entry tracker: Manhattan RGB distance of each streamed entry, keeps the first minimum.
module pncs_nearest (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pncs_pkg::scan_ctl_t               ctl_i,
  input  logic [pncs_pkg::COLOR_W-1:0]      color_i,
  input  logic [pncs_pkg::COLOR_W-1:0]      entry_i,
  output logic [pncs_pkg::ADDR_W-1:0]       best_idx_o,
  output logic [pncs_pkg::COLOR_W-1:0]      best_val_o
);

  localparam int unsigned CW = pncs_pkg::CHAN_W;
  localparam int unsigned DW = pncs_pkg::DIST_W;

  logic [CW-1:0] ad_r, ad_g, ad_b;
  logic [DW-1:0] ent_dist;
  logic          take;

  logic                         have_q, have_d;
  logic [DW-1:0]                best_dist_q, best_dist_d;
  logic [pncs_pkg::ADDR_W-1:0]  best_idx_q, best_idx_d;
  logic [pncs_pkg::COLOR_W-1:0] best_val_q, best_val_d;

  // per-channel absolute differences and their sum
  always_comb begin
    logic [CW-1:0] cr, cg, cb, er, eg, eb;
    cr = color_i[3*CW-1:2*CW];
    cg = color_i[2*CW-1:CW];
    cb = color_i[CW-1:0];
    er = entry_i[3*CW-1:2*CW];
    eg = entry_i[2*CW-1:CW];
    eb = entry_i[CW-1:0];
    ad_r = (cr > er) ? (cr - er) : (er - cr);
    ad_g = (cg > eg) ? (cg - eg) : (eg - cg);
    ad_b = (cb > eb) ? (cb - eb) : (eb - cb);
    ent_dist = DW'(ad_r) + DW'(ad_g) + DW'(ad_b);
  end

  // strict less-than keeps the lowest index on a tie
  assign take = ctl_i.vld && (!have_q || (ent_dist < best_dist_q));

  always_comb begin
    have_d      = have_q;
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    best_val_d  = best_val_q;
    if (ctl_i.start) begin
      have_d = 1'b0;
    end else if (take) begin
      have_d      = 1'b1;
      best_dist_d = ent_dist;
      best_idx_d  = ctl_i.idx;
      best_val_d  = entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_dist_q <= best_dist_d;
    best_idx_q  <= best_idx_d;
    best_val_q  <= best_val_d;
  end

  assign best_idx_o = best_idx_q;
  assign best_val_o = best_val_q;

endmodule

// ===== rtl/palette_nearest_color_select_top.sv =====
// Top level of the palette nearest-color selector: sequencer, color registers, output stage.
//
// Channels: an input item (opcode, color, is_index, target, entry_index) is taken when
// in_valid_i is high and in_stall_o low; one result item (status, color_value,
// color_index, palette_mode) leaves when out_valid_o is high and out_stall_i low.
// The configuration channel writes the palette size when cfg_valid_i and cfg_ready_o
// are high; it is always ready, and the user must see that it is written only while the
// block is idle; the block itself does not enforce this. A palette write, an out-of-range
// request, a read with no palette, a direct-mode set or an unused opcode goes from S_EXEC
// straight to S_RESULT; a palette read or a set by index passes S_LOOKUP; a set by RGB
// value passes S_SCAN and S_PICK, since the search streams the palette memory through
// its single read port, one entry a cycle. One item is in flight at a time; in_stall_o
// is high from the cycle after an item is taken until its result enters the output register.
// Reset clears the palette size (direct RGB mode), sets the foreground color to white
// and the background to black; the palette memory holds no defined contents until
// written. While the receiver stalls, the result waits in the output register and the
// next item is taken and worked on up to its own result, which then waits in turn.
module palette_nearest_color_select_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pncs_pkg::SIZE_W-1:0]       cfg_data_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        opcode_i,
  input  logic [pncs_pkg::COLOR_W-1:0]      color_i,
  input  logic                              is_index_i,
  input  logic                              target_i,
  input  logic [pncs_pkg::ADDR_W-1:0]       entry_index_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic [pncs_pkg::COLOR_W-1:0]      color_value_o,
  output logic [pncs_pkg::ADDR_W-1:0]       color_index_o,
  output logic                              palette_mode_o
);

  localparam int unsigned AW = pncs_pkg::ADDR_W;
  localparam int unsigned CW = pncs_pkg::COLOR_W;
  localparam int unsigned SW = pncs_pkg::SIZE_W;

  pncs_pkg::state_e state_q, state_d;

  // palette size register
  logic [SW-1:0] entries_q;
  logic [SW-1:0] size;
  logic          pal_mode;

  // latched item
  pncs_pkg::opcode_e op_q;
  logic [CW-1:0]     color_q;
  logic              is_index_q;
  logic              target_q;
  logic [AW-1:0]     entry_q;

  // color registers
  logic [CW-1:0] fg_q, fg_d, bg_q, bg_d;

  // pending result
  pncs_pkg::status_e res_status_q, res_status_d;
  logic [CW-1:0]     res_value_q, res_value_d;
  logic [AW-1:0]     res_idx_q, res_idx_d;
  logic [AW-1:0]     sel_q, sel_d;

  // search address counter and read tag
  logic [SW-1:0] scan_cnt_q, scan_cnt_d;
  logic          scan_vld_q;
  logic [AW-1:0] scan_idx_q;
  logic          scan_issue;
  logic          scan_start;

  // output register
  logic                  out_valid_q;
  pncs_pkg::status_e     out_status_q;
  logic [CW-1:0]         out_value_q;
  logic [AW-1:0]         out_idx_q;
  logic                  out_mode_q;
  logic                  out_load;

  // memory ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [CW-1:0] ram_rdata;

  pncs_pkg::scan_ctl_t   scan_ctl;
  logic [AW-1:0]         best_idx;
  logic [CW-1:0]         best_val;

  logic in_acc;

  // configuration: always ready, sizes above the table depth clamp
  assign cfg_ready_o = 1'b1;
  assign size     = (entries_q > pncs_pkg::DEPTH_SIZE) ? pncs_pkg::DEPTH_SIZE : entries_q;
  assign pal_mode = (size != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entries_q <= cfg_data_i;
    end
  end

  assign in_stall_o = (state_q != pncs_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == pncs_pkg::S_RESULT) && (!out_valid_q || !out_stall_i);

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q       <= pncs_pkg::opcode_e'(opcode_i);
      color_q    <= color_i;
      is_index_q <= is_index_i;
      target_q   <= target_i;
      entry_q    <= entry_index_i;
    end
  end

  // sequencer: next state, memory access, result and color register updates
  always_comb begin
    state_d      = state_q;
    fg_d         = fg_q;
    bg_d         = bg_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_idx_d    = res_idx_q;
    sel_d        = sel_q;
    scan_cnt_d   = scan_cnt_q;
    scan_issue   = 1'b0;
    scan_start   = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = entry_q;
    ram_wdata    = color_q;
    ram_re       = 1'b0;
    ram_raddr    = entry_q;

    case (state_q)
      pncs_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = pncs_pkg::S_EXEC;
        end
      end

      pncs_pkg::S_EXEC: begin
        res_status_d = pncs_pkg::ST_OK;
        res_value_d  = '0;
        res_idx_d    = '0;
        state_d      = pncs_pkg::S_RESULT;
        case (op_q)
          pncs_pkg::OP_WRITE: begin
            ram_we      = 1'b1;
            res_value_d = color_q;
            res_idx_d   = entry_q;
          end
          pncs_pkg::OP_READ: begin
            if (!pal_mode) begin
              res_status_d = pncs_pkg::ST_NO_PALETTE;
            end else if ({1'b0, entry_q} >= size) begin
              res_status_d = pncs_pkg::ST_RANGE;
            end else begin
              ram_re  = 1'b1;
              sel_d   = entry_q;
              state_d = pncs_pkg::S_LOOKUP;
            end
          end
          pncs_pkg::OP_SET: begin
            if (!pal_mode) begin
              // direct mode: raw RGB stored
              if (target_q) begin
                bg_d = color_q;
              end else begin
                fg_d = color_q;
              end
              res_value_d = color_q;
            end else if (is_index_q) begin
              if (color_q >= CW'(size)) begin
                res_status_d = pncs_pkg::ST_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = color_q[AW-1:0];
                sel_d     = color_q[AW-1:0];
                if (target_q) begin
                  bg_d = CW'(color_q[AW-1:0]);
                end else begin
                  fg_d = CW'(color_q[AW-1:0]);
                end
                state_d = pncs_pkg::S_LOOKUP;
              end
            end else begin
              // start nearest search at entry zero
              scan_start = 1'b1;
              scan_issue = 1'b1;
              ram_re     = 1'b1;
              ram_raddr  = '0;
              scan_cnt_d = SW'(1);
              state_d    = pncs_pkg::S_SCAN;
            end
          end
          default: begin
            // unused opcode: empty result
          end
        endcase
      end

      pncs_pkg::S_LOOKUP: begin
        res_status_d = pncs_pkg::ST_OK;
        res_value_d  = ram_rdata;
        res_idx_d    = sel_q;
        state_d      = pncs_pkg::S_RESULT;
      end

      pncs_pkg::S_SCAN: begin
        if (scan_cnt_q < size) begin
          scan_issue = 1'b1;
          ram_re     = 1'b1;
          ram_raddr  = scan_cnt_q[AW-1:0];
          scan_cnt_d = scan_cnt_q + SW'(1);
        end
        // last entry reaches the tracker this cycle
        if (scan_vld_q && ({1'b0, scan_idx_q} == (size - SW'(1)))) begin
          state_d = pncs_pkg::S_PICK;
        end
      end

      pncs_pkg::S_PICK: begin
        res_status_d = pncs_pkg::ST_OK;
        res_value_d  = best_val;
        res_idx_d    = best_idx;
        if (target_q) begin
          bg_d = CW'(best_idx);
        end else begin
          fg_d = CW'(best_idx);
        end
        state_d = pncs_pkg::S_RESULT;
      end

      pncs_pkg::S_RESULT: begin
        if (out_load) begin
          state_d = pncs_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pncs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pncs_pkg::S_IDLE;
      fg_q       <= pncs_pkg::FG_RESET;
      bg_q       <= pncs_pkg::BG_RESET;
      scan_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fg_q       <= fg_d;
      bg_q       <= bg_d;
      scan_vld_q <= scan_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_idx_q    <= res_idx_d;
    sel_q        <= sel_d;
    scan_cnt_q   <= scan_cnt_d;
    scan_idx_q   <= ram_raddr;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_idx_q    <= res_idx_q;
      out_mode_q   <= pal_mode;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign color_value_o  = out_value_q;
  assign color_index_o  = out_idx_q;
  assign palette_mode_o = out_mode_q;

  // palette memory
  pncs_palette_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // nearest-entry tracker
  assign scan_ctl.start = scan_start;
  assign scan_ctl.vld   = scan_vld_q && (state_q == pncs_pkg::S_SCAN);
  assign scan_ctl.idx   = scan_idx_q;

  pncs_nearest u_nearest (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .color_i    (color_q),
    .entry_i    (ram_rdata),
    .best_idx_o (best_idx),
    .best_val_o (best_val)
  );

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the palette nearest-color selector: random and directed items, predicted.
`timescale 1ns / 1ps

module tb_top;
  import pncs_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 250;
  localparam int NUM_PHASES   = 10;
  // palette size per random phase; a negative entry means "some value above the depth"
  localparam int PHASE_SIZE [NUM_PHASES]  = '{0, 3, 1, 16, 256, 2, 511, 40, -1, 7};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{40, 50, 30, 50, 20, 40, 15, 45, 15, 45};

  typedef struct packed {
    opcode_e              op;
    logic [COLOR_W-1:0]   color;
    logic                 is_index;
    logic                 target;
    logic [ADDR_W-1:0]    entry;
  } cmd_t;

  typedef struct packed {
    status_e              status;
    logic [COLOR_W-1:0]   value;
    logic [ADDR_W-1:0]    index;
    logic                 mode;
  } color_result_t;

  // Predicts the selector's result items and compares them with what comes out
  class palette_scoreboard;
    logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
    bit                 written [PALETTE_DEPTH];
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic [SIZE_W-1:0]  size_reg;
    color_result_t      expected_q [$];
    int                 errors;
    int                 checked;

    function new();
      fg_reg   = FG_RESET;
      bg_reg   = BG_RESET;
      size_reg = '0;
      errors   = 0;
      checked  = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function int used_size();
      return (size_reg > DEPTH_SIZE) ? int'(PALETTE_DEPTH) : int'(size_reg);
    endfunction

    function void set_size(logic [SIZE_W-1:0] v);
      size_reg = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int absdiff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // Work out the result of one accepted item and update the color state
    function void note_input(cmd_t c);
      color_result_t      r;
      int                 us;
      int                 best_d;
      int                 d;
      logic [COLOR_W-1:0] sel;
      logic [COLOR_W-1:0] e;
      us       = used_size();
      r.status = ST_OK;
      r.value  = '0;
      r.index  = '0;
      r.mode   = (us != 0);
      case (c.op)
        OP_WRITE: begin
          pal_mem[c.entry] = c.color;
          written[c.entry] = 1'b1;
          r.value = c.color;
          r.index = c.entry;
        end
        OP_SET: begin
          if (us == 0) begin
            if (c.target) bg_reg = c.color;
            else fg_reg = c.color;
            r.value = c.color;
          end else begin
            if (c.is_index) begin
              sel = c.color;
            end else begin
              // nearest entry by |dR|+|dG|+|dB|, lowest index on a tie
              sel    = '0;
              best_d = 1 << 30;
              for (int i = 0; i < us; i++) begin
                e = pal_mem[ADDR_W'(i)];
                d = absdiff(c.color[23:16], e[23:16]) + absdiff(c.color[15:8], e[15:8])
                  + absdiff(c.color[7:0], e[7:0]);
                if (d < best_d) begin
                  best_d = d;
                  sel    = COLOR_W'(i);
                end
              end
            end
            if (sel >= us) begin
              r.status = ST_RANGE;
            end else begin
              if (c.target) bg_reg = sel;
              else fg_reg = sel;
              r.value = pal_mem[sel[ADDR_W-1:0]];
              r.index = sel[ADDR_W-1:0];
            end
          end
        end
        OP_READ: begin
          if (us == 0) begin
            r.status = ST_NO_PALETTE;
          end else if (c.entry >= us) begin
            r.status = ST_RANGE;
          end else begin
            r.value = pal_mem[c.entry];
            r.index = c.entry;
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 50) $display("[%0t] ERROR: %s", $time, msg);
      errors++;
    endtask

    task check_result(color_result_t got);
      color_result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected item: status=%0d value=%06h index=%0d mode=%0d",
                         got.status, got.value, got.index, got.mode));
      end else begin
        exp_r = expected_q.pop_front();
        checked++;
        if (got.status !== exp_r.status || got.value !== exp_r.value ||
            got.index !== exp_r.index || got.mode !== exp_r.mode) begin
          report($sformatf("item %0d: got %0d/%06h/%0d/%0d, want %0d/%06h/%0d/%0d",
                           checked, got.status, got.value, got.index, got.mode,
                           exp_r.status, exp_r.value, exp_r.index, exp_r.mode));
        end
      end
    endtask
  endclass

  // DUT signals
  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [SIZE_W-1:0]  cfg_data     = '0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [1:0]         opcode       = '0;
  logic [COLOR_W-1:0] color        = '0;
  logic               is_index     = 1'b0;
  logic               target       = 1'b0;
  logic [ADDR_W-1:0]  entry_index  = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [1:0]         status;
  logic [COLOR_W-1:0] color_value;
  logic [ADDR_W-1:0]  color_index;
  logic               palette_mode;

  int                 cycle_count  = 0;
  palette_scoreboard  sb;

  palette_nearest_color_select_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .color_i        (color),
    .is_index_i     (is_index),
    .target_i       (target),
    .entry_index_i  (entry_index),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .color_value_o  (color_value),
    .color_index_o  (color_index),
    .palette_mode_o (palette_mode)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("palette_nearest_color_select_top: mismatch");
      $finish;
    end
  end

  function automatic cmd_t mk(opcode_e op, logic [COLOR_W-1:0] col, logic idx, logic tgt,
                              logic [ADDR_W-1:0] ent);
    cmd_t c;
    c.op       = op;
    c.color    = col;
    c.is_index = idx;
    c.target   = tgt;
    c.entry    = ent;
    return c;
  endfunction

  // Channel levels from a small set, so that equal distances show up often
  function automatic logic [CHAN_W-1:0] pick_chan();
    logic [CHAN_W-1:0] levels [5] = '{8'h00, 8'h40, 8'h80, 8'hC0, 8'hFF};
    return levels[3'($urandom_range(0, 4))];
  endfunction

  // Sender idle gap: mostly none or short, now and then long
  function automatic int pick_gap(bit burst);
    int roll;
    roll = int'($urandom_range(0, 99));
    if (burst || roll < 60) return 0;
    if (roll < 88) return int'($urandom_range(1, 3));
    if (roll < 98) return int'($urandom_range(4, 15));
    return int'($urandom_range(30, 80));
  endfunction

  // Offer one item after an optional gap and wait until it is taken
  task automatic send_cmd(cmd_t c, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= c.op;
    color       <= c.color;
    is_index    <= c.is_index;
    target      <= c.target;
    entry_index <= c.entry;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(c);
  endtask

  // Change the palette size once every result is out and the block is idle
  task automatic write_size(logic [SIZE_W-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_size(v);
  endtask

  // Result side: check taken items, stall at random, one long hold-off now and then
  initial begin : result_sink
    color_result_t got;
    int            stall_left;
    int            free_left;
    int            hold_left;
    int            next_hold;
    int            roll;
    stall_left = 0;
    free_left  = 0;
    hold_left  = 0;
    next_hold  = 120;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.status = status_e'(status);
        got.value  = color_value;
        got.index  = color_index;
        got.mode   = palette_mode;
        sb.check_result(got);
      end
      if (hold_left == 0 && next_hold > 0 && sb.checked >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold = (next_hold < 400) ? 420 : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (free_left > 0) begin
          free_left--;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 3) free_left = $urandom_range(30, 120);
          else if (roll < 20) stall_left = $urandom_range(1, 3);
          else if (roll < 24) stall_left = $urandom_range(4, 12);
          else if (roll < 26) stall_left = $urandom_range(20, 60);
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    cmd_t               c;
    int                 us;
    int                 sz;
    int                 roll;
    int                 r2;
    bit                 burst;
    logic [COLOR_W-1:0] base;
    logic [5:0]         tweak;
    sb = new();
    burst = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // direct RGB mode: raw stores, read without palette, unused opcode, table loads
    write_size('0);
    send_cmd(mk(OP_SET, 24'h000000, 1'b0, 1'b0, 8'h00), pick_gap(0));
    send_cmd(mk(OP_SET, 24'hFFFFFF, 1'b1, 1'b1, 8'hFF), pick_gap(0));
    send_cmd(mk(OP_READ, 24'h000000, 1'b0, 1'b0, 8'h00), pick_gap(0));
    send_cmd(mk(OP_NONE, 24'hFFFFFF, 1'b1, 1'b1, 8'hFF), pick_gap(0));
    send_cmd(mk(OP_WRITE, 24'h000000, 1'b0, 1'b0, 8'd0), pick_gap(0));
    send_cmd(mk(OP_WRITE, 24'hFFFFFF, 1'b1, 1'b1, 8'd1), pick_gap(0));
    send_cmd(mk(OP_WRITE, 24'h102030, 1'b0, 1'b0, 8'd2), pick_gap(0));
    send_cmd(mk(OP_WRITE, 24'h302030, 1'b0, 1'b1, 8'd3), pick_gap(0));
    send_cmd(mk(OP_WRITE, 24'hA5A5A5, 1'b0, 1'b0, 8'd255), pick_gap(0));

    // four-entry palette: range edges, index sets, nearest search with a tie
    write_size(SIZE_W'(4));
    send_cmd(mk(OP_READ, 24'h000000, 1'b0, 1'b0, 8'd0), pick_gap(0));
    send_cmd(mk(OP_READ, 24'h000000, 1'b0, 1'b0, 8'd3), pick_gap(0));
    send_cmd(mk(OP_READ, 24'h000000, 1'b0, 1'b0, 8'd4), pick_gap(0));
    send_cmd(mk(OP_READ, 24'h000000, 1'b0, 1'b0, 8'd255), pick_gap(0));
    send_cmd(mk(OP_SET, 24'd3, 1'b1, 1'b0, 8'd0), pick_gap(0));
    send_cmd(mk(OP_SET, 24'd4, 1'b1, 1'b1, 8'd0), pick_gap(0));
    send_cmd(mk(OP_SET, 24'hFFFFFF, 1'b1, 1'b0, 8'd0), pick_gap(0));
    send_cmd(mk(OP_SET, 24'h202030, 1'b0, 1'b0, 8'd0), pick_gap(0));  // equal to 2 and 3
    send_cmd(mk(OP_SET, 24'hFFFFFF, 1'b0, 1'b1, 8'd0), pick_gap(0));
    send_cmd(mk(OP_SET, 24'h000000, 1'b0, 1'b1, 8'd0), pick_gap(0));
    send_cmd(mk(OP_SET, 24'h808080, 1'b0, 1'b0, 8'd0), pick_gap(0));
    send_cmd(mk(OP_NONE, 24'h000000, 1'b0, 1'b0, 8'd0), pick_gap(0));

    // random phases over a range of palette sizes
    for (int p = 0; p < NUM_PHASES; p++) begin
      sz = (PHASE_SIZE[p] < 0) ? int'($urandom_range(PALETTE_DEPTH + 1, 511)) : PHASE_SIZE[p];
      write_size(SIZE_W'(sz));
      us = sb.used_size();
      // load every entry in use that was never written
      for (int i = 0; i < us; i++) begin
        if (!sb.written[ADDR_W'(i)]) begin
          send_cmd(mk(OP_WRITE, COLOR_W'($urandom_range(0, 24'hFFFFFF)), 1'b0, 1'b0,
                      ADDR_W'(i)), pick_gap(0));
        end
      end
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        roll       = $urandom_range(0, 99);
        r2         = $urandom_range(0, 99);
        c.target   = 1'($urandom_range(0, 1));
        c.is_index = 1'($urandom_range(0, 1));
        c.entry    = ADDR_W'($urandom_range(0, 255));
        c.color    = COLOR_W'($urandom_range(0, 24'hFFFFFF));
        if (roll < 20) begin
          c.op = OP_WRITE;
          if (r2 < 50) c.color = {pick_chan(), pick_chan(), pick_chan()};
          if (us > 0 && $urandom_range(0, 1)) c.entry = ADDR_W'($urandom_range(0, us - 1));
        end else if (roll < 45) begin
          // set by index, mostly in range, sometimes right at the edge
          c.op = OP_SET;
          if (us > 0) begin
            c.is_index = 1'b1;
            if (r2 < 80) c.color = COLOR_W'($urandom_range(0, us - 1));
            else if (r2 < 90) c.color = COLOR_W'(us);
          end
        end else if (roll < 70) begin
          // set by RGB value: coarse levels, near an entry, or anything
          c.op = OP_SET;
          if (us > 0) begin
            c.is_index = 1'b0;
            if (r2 < 40) begin
              c.color = {pick_chan(), pick_chan(), pick_chan()};
            end else if (r2 < 70) begin
              base    = sb.pal_mem[ADDR_W'($urandom_range(0, us - 1))];
              tweak   = 6'($urandom_range(0, 63));
              c.color = base ^ {6'b0, tweak[5:4], 6'b0, tweak[3:2], 6'b0, tweak[1:0]};
            end
          end
        end else if (roll < 92) begin
          c.op = OP_READ;
          if (us > 0 && r2 < 75) c.entry = ADDR_W'($urandom_range(0, us - 1));
        end else begin
          c.op = OP_NONE;
        end
        send_cmd(c, pick_gap(burst));
      end
    end

    // drain
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("palette_nearest_color_select_top: match");
    end else begin
      $display("palette_nearest_color_select_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pncs_pkg.sv
rtl/pncs_palette_ram.sv
rtl/pncs_nearest.sv
rtl/palette_nearest_color_select_top.sv
sim/tb_top.sv
